[rtl/fsq_pkg.sv]
// ----------------------------------------------------------------------------
// fsq_pkg
// Shared types, constants and letter helpers for the four-square pair cipher.
// ----------------------------------------------------------------------------
package fsq_pkg;

	localparam int SQ_CELLS = 25;
	localparam int CFG_W    = 60;

	// letter indices into the plain alphabet without j
	localparam logic [4:0] LETTER_I   = 5'd8;
	localparam logic [4:0] LETTER_X   = 5'd22;
	localparam logic [4:0] LETTER_MAX = 5'd24;

	localparam logic [7:0] CHAR_A = 8'd65;
	localparam logic [7:0] CHAR_J = 8'd74;
	localparam logic [7:0] CHAR_Z = 8'd90;

	// configuration register indexes
	localparam logic [2:0] REG_DIRECTION = 3'd0;
	localparam logic [2:0] REG_UPPER_LOW = 3'd1;
	localparam logic [2:0] REG_UPPER_MID = 3'd2;
	localparam logic [2:0] REG_UPPER_TOP = 3'd3;
	localparam logic [2:0] REG_LOWER_LOW = 3'd4;
	localparam logic [2:0] REG_LOWER_MID = 3'd5;
	localparam logic [2:0] REG_LOWER_TOP = 3'd6;

	typedef logic [4:0] letter_t;
	typedef logic [SQ_CELLS-1:0][4:0] square_t;

	typedef struct packed {
		logic    direction;
		square_t upper;
		square_t lower;
	} cfg_t;

	typedef struct packed {
		letter_t a;
		letter_t b;
		logic    last;
	} pair_t;

	function automatic logic [2:0] row_of(input letter_t v);
		logic [2:0] r;
		if (v < 5'd5)       r = 3'd0;
		else if (v < 5'd10) r = 3'd1;
		else if (v < 5'd15) r = 3'd2;
		else if (v < 5'd20) r = 3'd3;
		else                r = 3'd4;
		return r;
	endfunction

	function automatic logic [4:0] row_base(input logic [2:0] r);
		return ({2'b00, r} << 2) + {2'b00, r};
	endfunction

	function automatic logic [2:0] col_of(input letter_t v);
		logic [4:0] d;
		d = v - row_base(row_of(v));
		return d[2:0];
	endfunction

	function automatic letter_t cell_at(input logic [2:0] r, input logic [2:0] c);
		return row_base(r) + {2'b00, c};
	endfunction

	function automatic logic [6:0] to_ascii(input letter_t v);
		letter_t w;
		w = (v > LETTER_MAX) ? LETTER_MAX : v;
		return (w < LETTER_I + 5'd1) ? 7'd65 + {2'b00, w} : 7'd66 + {2'b00, w};
	endfunction

endpackage

[rtl/fsq_front.sv]
// ----------------------------------------------------------------------------
// fsq_front
// Takes message bytes, drops non-letters, maps letters to indices and pairs
// them up; each finished pair is pushed into the pair queue.
// ----------------------------------------------------------------------------
module fsq_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     in_char,
	input  logic           in_last,
	input  logic           direction,
	input  logic           q_full,
	output logic           push,
	output fsq_pkg::pair_t push_data
);
	import fsq_pkg::*;

	letter_t held_q;
	logic    half_q;
	logic    accept;
	logic    is_letter;
	letter_t v;
	letter_t second;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		is_letter = 1'b0;
		v         = '0;
		if (in_char >= CHAR_A && in_char <= CHAR_Z) begin
			if (in_char == CHAR_J) begin
				// j folds into i on encrypt, has no cell on decrypt
				is_letter = !direction;
				v         = LETTER_I;
			end else if (in_char < CHAR_J) begin
				is_letter = 1'b1;
				v         = 5'(in_char - CHAR_A);
			end else begin
				is_letter = 1'b1;
				v         = 5'(in_char - CHAR_A - 8'd1);
			end
		end
	end

	assign second = (v == held_q) ? LETTER_X : v;

	always_comb begin
		push      = 1'b0;
		push_data = '0;
		if (accept) begin
			if (is_letter && !half_q && in_last) begin
				push      = 1'b1;
				push_data = '{a: v, b: LETTER_X, last: 1'b1};
			end else if (is_letter && half_q) begin
				push      = 1'b1;
				push_data = '{a: held_q, b: second, last: in_last};
			end else if (!is_letter && in_last && half_q) begin
				push      = 1'b1;
				push_data = '{a: held_q, b: LETTER_X, last: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			half_q <= 1'b0;
		end else if (accept) begin
			if (is_letter && !half_q && !in_last) begin
				held_q <= v;
				half_q <= 1'b1;
			end else if (push) begin
				half_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/fsq_queue.sv]
// ----------------------------------------------------------------------------
// fsq_queue
// Small register queue of letter pairs between the front and the back.
// ----------------------------------------------------------------------------
module fsq_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fsq_pkg::pair_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output fsq_pkg::pair_t head_data
);
	import fsq_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	pair_t         slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_pop;

	assign full       = (cnt_q == FULL_CNT);
	assign head_valid = (cnt_q != '0);
	assign head_data  = slot_q[rd_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_SLOT) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_SLOT) ? '0 : rd_q + PW'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

[rtl/fsq_back.sv]
// ----------------------------------------------------------------------------
// fsq_back
// Applies the rectangle rule to each queued pair and hands out the two
// resulting letters one word at a time.
// ----------------------------------------------------------------------------
module fsq_back (
	input  logic           clk,
	input  logic           arst_n,
	input  fsq_pkg::cfg_t  cfg,
	input  logic           head_valid,
	input  fsq_pkg::pair_t head_data,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [6:0]     out_char,
	output logic           out_last
);
	import fsq_pkg::*;

	logic       v_s1;
	letter_t    a_s1;
	letter_t    b_s1;
	logic       last_s1;
	logic       v_s2;
	letter_t    pa_s2;
	letter_t    pb_s2;
	logic       last_s2;
	logic       ov_q;
	logic       phase_q;
	logic [6:0] c1_q;
	logic [6:0] c2_q;
	logic       olast_q;

	logic       out_free;
	logic       adv2;
	logic       move1;
	letter_t    pa;
	letter_t    pb;
	letter_t    i1;
	letter_t    i2;
	letter_t    o1;
	letter_t    o2;

	// first matching cell in row-major order, cell 0 when none matches
	function automatic letter_t find_cell(input square_t sq, input letter_t key);
		letter_t pos;
		pos = '0;
		for (int k = SQ_CELLS - 1; k >= 0; k--) begin
			if (sq[k] == key) pos = 5'(k);
		end
		return pos;
	endfunction

	assign out_free = !ov_q || (phase_q && !out_stall);
	assign adv2     = v_s2 && out_free;
	assign move1    = v_s1 && (!v_s2 || adv2);
	assign pop      = head_valid && (!v_s1 || move1);

	// stage 1: positions in the keyed squares (decrypt) or plain square
	assign pa = cfg.direction ? find_cell(cfg.upper, a_s1) : a_s1;
	assign pb = cfg.direction ? find_cell(cfg.lower, b_s1) : b_s1;

	// stage 2: swap columns, read keyed cells when encrypting
	assign i1 = cell_at(row_of(pa_s2), col_of(pb_s2));
	assign i2 = cell_at(row_of(pb_s2), col_of(pa_s2));
	assign o1 = cfg.direction ? i1 : cfg.upper[i1];
	assign o2 = cfg.direction ? i2 : cfg.lower[i2];

	assign out_valid = ov_q;
	assign out_char  = phase_q ? c2_q : c1_q;
	assign out_last  = phase_q && olast_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			a_s1    <= head_data.a;
			b_s1    <= head_data.b;
			last_s1 <= head_data.last;
		end
		if (move1) begin
			pa_s2   <= pa;
			pb_s2   <= pb;
			last_s2 <= last_s1;
		end
		if (adv2) begin
			c1_q    <= to_ascii(o1);
			c2_q    <= to_ascii(o2);
			olast_q <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			ov_q    <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (pop) begin
				v_s1 <= 1'b1;
			end else if (move1) begin
				v_s1 <= 1'b0;
			end
			if (move1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
			if (adv2) begin
				ov_q    <= 1'b1;
				phase_q <= 1'b0;
			end else if (ov_q && !out_stall) begin
				if (phase_q) begin
					ov_q <= 1'b0;
				end else begin
					phase_q <= 1'b1;
				end
			end
		end
	end

endmodule

[rtl/four_square_pair_cipher.sv]
// ----------------------------------------------------------------------------
// four_square_pair_cipher
// Streaming four-square cipher: pairs letters and emits two letters a pair.
// ----------------------------------------------------------------------------
// The block takes one message byte per cycle. Letters are paired in the front
// end and each pair goes through a small queue to a two-stage back end (square
// lookup, then column swap and cell read) and an output register that hands
// out the pair's first letter and then its second. Output bandwidth is one
// letter per cycle while the output is not stalled, so ordinary text streams
// at one byte per cycle; the input only stalls when the queue fills, which
// happens when the output is stalled or when many final bytes each pad a lone
// letter into a pair. A pair is registered in the queue, then in stage 1,
// stage 2 and the output register; the second letter is offered the cycle
// after the first one is taken. The user must write squares and direction
// via the configuration port only while idle; the block does not enforce this.
module four_square_pair_cipher #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [fsq_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 in_char,
	input  logic                       in_last,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [6:0]                 out_char,
	output logic                       out_last
);
	import fsq_pkg::*;

	logic    direction_q;
	square_t upper_q;
	square_t lower_q;
	cfg_t    cfg;
	logic    push;
	pair_t   push_data;
	logic    q_full;
	logic    pop;
	logic    head_valid;
	pair_t   head_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
			upper_q     <= '0;
			lower_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIRECTION: direction_q <= cfg_data[0];
				REG_UPPER_LOW: begin
					for (int k = 0; k < 12; k++) upper_q[k] <= cfg_data[5*k +: 5];
				end
				REG_UPPER_MID: begin
					for (int k = 0; k < 12; k++) upper_q[12 + k] <= cfg_data[5*k +: 5];
				end
				REG_UPPER_TOP: upper_q[SQ_CELLS-1] <= cfg_data[4:0];
				REG_LOWER_LOW: begin
					for (int k = 0; k < 12; k++) lower_q[k] <= cfg_data[5*k +: 5];
				end
				REG_LOWER_MID: begin
					for (int k = 0; k < 12; k++) lower_q[12 + k] <= cfg_data[5*k +: 5];
				end
				REG_LOWER_TOP: lower_q[SQ_CELLS-1] <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign cfg = '{direction: direction_q, upper: upper_q, lower: lower_q};

	fsq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_char   (in_char),
		.in_last   (in_last),
		.direction (direction_q),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	fsq_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	fsq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.out_last   (out_last)
	);

endmodule

[rtl/fsq_checker.sv]
// ----------------------------------------------------------------------------
// fsq_checker
// Port-level checks on the cipher's output stream, bound to the top level.
// ----------------------------------------------------------------------------
module fsq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [6:0] out_char,
	input logic       out_last
);
	import fsq_pkg::*;

	// high after the first letter of a pair has been taken
	logic second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
		end else if (out_valid && !out_stall) begin
			second_q <= !second_q;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_last))
		else $error("output word changed while stalled");

	a_letter: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_char >= 7'd65 && out_char <= 7'd90 && out_char != 7'd74)
		else $error("output is not a square letter");

	a_last_second: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> second_q)
		else $error("last flag on the first letter of a pair");

	a_pair_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_last |=> !second_q)
		else $error("pair count out of step after last letter");

endmodule

bind four_square_pair_cipher fsq_checker u_fsq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_char  (out_char),
	.out_last  (out_last)
);
